/* src/brlf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brlf_pkg
// Shared constants, codes and control types for the byte ring with line
// frame extraction.
// ----------------------------------------------------------------------------
package brlf_pkg;

    localparam int RING_DEPTH = 256;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int BLEN_W     = 16;
    localparam int LIM_W      = 7;
    localparam int STAT_W     = 3;

    localparam logic [LIM_W-1:0] LIMIT_MIN   = 7'd2;
    localparam logic [LIM_W-1:0] LIMIT_MAX   = 7'd64;
    localparam logic [LIM_W-1:0] LIMIT_RESET = 7'd64;

    localparam logic [7:0] NEWLINE = 8'h0A;

    localparam logic [STAT_W-1:0] ST_FRAME    = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOFRAME  = 3'd1;
    localparam logic [STAT_W-1:0] ST_LIMIT    = 3'd2;
    localparam logic [STAT_W-1:0] ST_STORED   = 3'd3;
    localparam logic [STAT_W-1:0] ST_REJECTED = 3'd4;

    localparam logic MODE_WRITE    = 1'b0;
    localparam logic MODE_RETRIEVE = 1'b1;

    typedef struct packed {
        logic acc_write;
        logic scan_start;
        logic fetch;
        logic emit_byte;
        logic emit_noframe;
        logic emit_limit;
        logic emit_frame;
    } brlf_cmd_t;

    typedef struct packed {
        logic out_free;
        logic scan_end;
        logic scan_limit;
        logic is_newline;
    } brlf_stat_t;

endpackage
`default_nettype wire

/* src/byte_ring_with_line_frame_extract.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_with_line_frame_extract
// Circular byte store with block admission and newline frame extraction.
// ----------------------------------------------------------------------------
// A write transaction (tuser bit 0 low) offers one byte of a block and is
// answered by one status transaction in the next cycle; writes run at one per
// cycle while results are taken. A retrieve transaction scans the ring from
// the read pointer, returning each scanned byte and then one status
// transaction with tlast set. Each byte is taken from the ring memory by a
// registered read and then returned, and no new transaction is accepted
// until the status has been issued. The receive limit may be written at
// any time the block is idle and defaults to 64.
// ----------------------------------------------------------------------------
module byte_ring_with_line_frame_extract (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // data_byte, block_len
    input  wire logic [1:0]  s_axis_tuser,   // mode, first_in_block
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // out_byte, frame_length, zero pad
    output logic [3:0]       m_axis_tuser,   // byte_valid, status
    output logic             m_axis_tlast,
    input  wire logic        cfg_wr_en,
    input  wire logic [6:0]  cfg_wr_data     // receive_limit
);

    brlf_pkg::brlf_cmd_t  cmd;
    brlf_pkg::brlf_stat_t stat;

    logic [7:0]                        out_byte;
    logic                              out_bvalid;
    logic [brlf_pkg::STAT_W-1:0]       out_status;
    logic [brlf_pkg::LIM_W-1:0]        out_flen;

    brlf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_mode  (s_axis_tuser[0]),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    brlf_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .in_byte        (s_axis_tdata[7:0]),
        .in_first       (s_axis_tuser[1]),
        .in_blen        (s_axis_tdata[23:8]),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .out_byte       (out_byte),
        .out_byte_valid (out_bvalid),
        .out_status     (out_status),
        .out_flen       (out_flen),
        .out_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_flen, out_byte};
    assign m_axis_tuser = {out_status, out_bvalid};

    a_retrieve_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[0] |=> !s_axis_tready)
        else $error("input accepted during a retrieve");

    a_byte_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tlast
            && m_axis_tuser[3:1] == brlf_pkg::ST_FRAME)
        else $error("scanned byte flagged as final or with status");

    a_flen_only_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[14:8] != 7'd0 |->
            m_axis_tlast && m_axis_tuser[3:1] == brlf_pkg::ST_FRAME)
        else $error("frame length outside a frame status");

    a_write_answer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] |=>
            m_axis_tvalid && m_axis_tlast
            && (m_axis_tuser[3:1] == brlf_pkg::ST_STORED
                || m_axis_tuser[3:1] == brlf_pkg::ST_REJECTED))
        else $error("write not answered with a write status");

endmodule
`default_nettype wire

/* src/brlf_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brlf_dp
// Datapath: ring store, pointers, block admission, scan position and count,
// and the result register.
// ----------------------------------------------------------------------------
module brlf_dp (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire brlf_pkg::brlf_cmd_t        cmd,
    output brlf_pkg::brlf_stat_t            stat,
    input  wire logic [7:0]                 in_byte,
    input  wire logic                       in_first,
    input  wire logic [brlf_pkg::BLEN_W-1:0] in_blen,
    input  wire logic                       cfg_wr_en,
    input  wire logic [brlf_pkg::LIM_W-1:0] cfg_wr_data,
    input  wire logic                       out_ready,
    output logic                            out_valid,
    output logic [7:0]                      out_byte,
    output logic                            out_byte_valid,
    output logic [brlf_pkg::STAT_W-1:0]     out_status,
    output logic [brlf_pkg::LIM_W-1:0]      out_flen,
    output logic                            out_last
);

    localparam int PW = brlf_pkg::PTR_W;

    logic [7:0]                   mem [brlf_pkg::RING_DEPTH];
    logic [PW-1:0]                rd_ptr_reg, wr_ptr_reg, pos_reg;
    logic [brlf_pkg::BLEN_W-1:0]  rem_reg;
    logic                         drop_reg;
    logic [brlf_pkg::LIM_W-1:0]   limit_reg, cnt_reg;
    logic [7:0]                   rd_data_reg;

    logic                         valid_reg, bvalid_reg, last_reg;
    logic [7:0]                   byte_reg;
    logic [brlf_pkg::STAT_W-1:0]  status_reg;
    logic [brlf_pkg::LIM_W-1:0]   flen_reg;

    logic [PW:0]                  used, space;
    logic                         drop_next;
    logic [brlf_pkg::BLEN_W-1:0]  rem_next;
    logic                         do_store;
    logic [brlf_pkg::LIM_W-1:0]   lim_eff;
    logic [PW-1:0]                wr_ptr_inc, pos_inc;
    logic                         emit_any;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(brlf_pkg::RING_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_comb begin
        if (wr_ptr_reg >= rd_ptr_reg) begin
            used = {1'b0, wr_ptr_reg} - {1'b0, rd_ptr_reg};
        end else begin
            used = {1'b0, wr_ptr_reg} + (PW+1)'(brlf_pkg::RING_DEPTH) - {1'b0, rd_ptr_reg};
        end
        space = (PW+1)'(brlf_pkg::RING_DEPTH - 1) - used;

        drop_next = drop_reg;
        rem_next  = rem_reg;
        if (in_first) begin
            drop_next = in_blen > brlf_pkg::BLEN_W'(space);
            rem_next  = drop_next ? '0 : in_blen;
        end
        do_store = !drop_next && (rem_next != '0);

        if (limit_reg < brlf_pkg::LIMIT_MIN) begin
            lim_eff = brlf_pkg::LIMIT_MIN;
        end else if (limit_reg > brlf_pkg::LIMIT_MAX) begin
            lim_eff = brlf_pkg::LIMIT_MAX;
        end else begin
            lim_eff = limit_reg;
        end

        wr_ptr_inc = ptr_inc(wr_ptr_reg);
        pos_inc    = ptr_inc(pos_reg);
        emit_any   = cmd.acc_write | cmd.emit_byte | cmd.emit_noframe
                   | cmd.emit_limit | cmd.emit_frame;
    end

    assign stat.out_free   = !valid_reg || out_ready;
    assign stat.scan_end   = (pos_reg == wr_ptr_reg);
    assign stat.scan_limit = (cnt_reg + brlf_pkg::LIM_W'(1)) >= lim_eff;
    assign stat.is_newline = (rd_data_reg == brlf_pkg::NEWLINE);

    // ring store: write on admitted bytes, registered read on fetch
    always_ff @(posedge aclk) begin
        if (cmd.acc_write && do_store) begin
            mem[wr_ptr_reg] <= in_byte;
        end
        if (cmd.fetch) begin
            rd_data_reg <= mem[pos_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            rem_reg    <= '0;
            drop_reg   <= 1'b0;
            limit_reg  <= brlf_pkg::LIMIT_RESET;
            pos_reg    <= '0;
            cnt_reg    <= '0;
            valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (cmd.acc_write) begin
                drop_reg <= drop_next;
                if (do_store) begin
                    wr_ptr_reg <= wr_ptr_inc;
                    rem_reg    <= rem_next - brlf_pkg::BLEN_W'(1);
                end else begin
                    rem_reg    <= rem_next;
                end
            end
            if (cmd.scan_start) begin
                pos_reg <= rd_ptr_reg;
                cnt_reg <= '0;
            end
            if (cmd.fetch) begin
                cnt_reg <= cnt_reg + brlf_pkg::LIM_W'(1);
            end
            if (cmd.emit_byte) begin
                pos_reg <= pos_inc;
            end
            if (cmd.emit_limit || cmd.emit_frame) begin
                rd_ptr_reg <= pos_reg;
            end
            if (emit_any) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_any) begin
            byte_reg   <= cmd.emit_byte ? rd_data_reg : 8'd0;
            bvalid_reg <= cmd.emit_byte;
            flen_reg   <= cmd.emit_frame ? cnt_reg : '0;
            last_reg   <= !cmd.emit_byte;
            if (cmd.acc_write) begin
                status_reg <= do_store ? brlf_pkg::ST_STORED : brlf_pkg::ST_REJECTED;
            end else if (cmd.emit_noframe) begin
                status_reg <= brlf_pkg::ST_NOFRAME;
            end else if (cmd.emit_limit) begin
                status_reg <= brlf_pkg::ST_LIMIT;
            end else begin
                status_reg <= brlf_pkg::ST_FRAME;
            end
        end
    end

    assign out_valid      = valid_reg;
    assign out_byte       = byte_reg;
    assign out_byte_valid = bvalid_reg;
    assign out_status     = status_reg;
    assign out_flen       = flen_reg;
    assign out_last       = last_reg;

endmodule
`default_nettype wire

/* src/brlf_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brlf_ctrl
// Controller: accepts transactions and sequences the frame scan.
// ----------------------------------------------------------------------------
module brlf_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    input  wire logic                 in_mode,
    output logic                      in_ready,
    input  wire brlf_pkg::brlf_stat_t stat,
    output brlf_pkg::brlf_cmd_t       cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_EMIT  = 2'd2;
    localparam logic [1:0] S_FRAME = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready = stat.out_free;
                if (in_valid && stat.out_free) begin
                    if (in_mode == brlf_pkg::MODE_WRITE) begin
                        cmd.acc_write = 1'b1;
                    end else begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                if (stat.scan_end) begin
                    if (stat.out_free) begin
                        cmd.emit_noframe = 1'b1;
                        state_next       = S_IDLE;
                    end
                end else if (stat.scan_limit) begin
                    if (stat.out_free) begin
                        cmd.emit_limit = 1'b1;
                        state_next     = S_IDLE;
                    end
                end else begin
                    cmd.fetch  = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit_byte = 1'b1;
                    state_next    = stat.is_newline ? S_FRAME : S_FETCH;
                end
            end
            S_FRAME: begin
                if (stat.out_free) begin
                    cmd.emit_frame = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire
